// ----- sv/btp_pkg.sv -----
package btp_pkg;

  // direct-mapped table geometry
  localparam int unsigned INDEX_BITS = 6;
  localparam int unsigned ENTRIES    = 1 << INDEX_BITS;

  // rv32 opcodes of control transfers
  localparam logic [6:0] OP_BRANCH = 7'd99;
  localparam logic [6:0] OP_JALR   = 7'd103;
  localparam logic [6:0] OP_JAL    = 7'd111;

  // predictor modes
  typedef enum logic [1:0] {
    MODE_TAKEN     = 2'd0,
    MODE_NOT_TAKEN = 2'd1,
    MODE_ONE_BIT   = 2'd2,
    MODE_TWO_BIT   = 2'd3
  } mode_t;

  // counter codes
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  typedef logic [INDEX_BITS-1:0] idx_t;

  // one table entry; valid comes from flops, the rest from the memory
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] target;
    logic [1:0]  ctr;
  } entry_t;

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  endfunction

endpackage

// ----- sv/btp_table.sv -----
module btp_table (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  btp_pkg::idx_t   rd_idx,
  output btp_pkg::entry_t rd_entry,
  input  logic            wr_en,
  input  btp_pkg::idx_t   wr_idx,
  input  btp_pkg::entry_t wr_entry
);
  import btp_pkg::*;

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  entry_t rd_q_r;
  logic   rd_vld_r;
  logic   byp_r;
  entry_t byp_data_r;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_idx];
      byp_data_r <= wr_entry;
    end
  end

  // valid bits and bypass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        // a write landing on the same edge is forwarded, memory reads old data
        byp_r    <= wr_en && (wr_idx == rd_idx);
        rd_vld_r <= valid_r[rd_idx] || (wr_en && (wr_idx == rd_idx));
      end
    end
  end

  always_comb begin
    rd_entry       = byp_r ? byp_data_r : rd_q_r;
    rd_entry.valid = rd_vld_r;
  end

`ifndef NO_ASSERTIONS
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_idx)])
    else $error("written entry not marked valid");

  a_forward_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && rd_idx == wr_idx) |=>
      (rd_entry.valid && rd_entry.tag == $past(wr_entry.tag)
       && rd_entry.ctr == $past(wr_entry.ctr)))
    else $error("same-entry write not forwarded to read");
`endif

endmodule

// ----- sv/branch_target_predictor.sv -----
// Branch target predictor over a trace of rv32 instructions. Each input item is
// one record (pc, instruction word, address that followed); each item gives
// exactly one result item. Conditional branches, jal and jalr are looked up in
// a direct-mapped target buffer of 2^INDEX_BITS entries with a full 32-bit tag;
// a miss or tag conflict allocates the entry (target pc+imm, or the observed
// next address for jalr) from a strong not-taken counter, updated by the
// item's outcome. The prediction comes from cfg_predictor_mode (0 always taken,
// 1 never, 2 last outcome, 3 two-bit counter, reset 3). Non-transfer items give
// an all-zero result and leave the state alone. Throughput is one item per
// cycle unless out_stall holds the result: the table memory is read on the edge
// that accepts an item, and the compare, counter update and write-back happen
// as the lookup stage loads the result register; back-to-back items to the same
// entry are served by a bypass of the write data. Valid bits live in flops and
// clear at reset, so no clearing pass is needed. cfg_predictor_mode must only
// be written while the block is idle; cfg_ready is always high.
module branch_target_predictor (
  input  logic        clk,
  input  logic        rst_n,
  // trace items in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_branch_pc,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_next_pc,
  // result items out
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_branch,
  output logic        out_hit,
  output logic        out_predicted_taken,
  output logic        out_actual_taken,
  output logic        out_correct,
  output logic [31:0] out_target_addr,
  output logic [31:0] out_correct_total,
  output logic [31:0] out_branch_total,
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_predictor_mode
);
  import btp_pkg::*;

  // mode register
  mode_t mode_r;

  // lookup stage: item whose table read is in flight
  logic        s1_valid_r;
  logic [31:0] s1_pc_r;
  logic [31:0] s1_instr_r;
  logic [31:0] s1_next_r;

  // result register
  logic        out_valid_r;
  logic        out_is_branch_r;
  logic        out_hit_r;
  logic        out_pred_r;
  logic        out_taken_r;
  logic        out_correct_r;
  logic [31:0] out_target_r;

  // running totals, saturating
  logic [31:0] correct_total_r;
  logic [31:0] branch_total_r;
  logic [31:0] correct_total_nxt;
  logic [31:0] branch_total_nxt;

  logic   in_acc;
  logic   s1_adv;
  entry_t rd_entry;
  entry_t wr_entry;
  logic   wr_en;

  // combinational results of the lookup stage
  logic [6:0]  op;
  logic        is_xfer;
  logic        hit;
  logic        taken;
  logic        pred;
  logic        ok;
  logic [1:0]  ctr_cur;
  logic [1:0]  ctr_new;
  logic [31:0] target_new;
  logic [31:0] target_use;

  assign cfg_ready = 1'b1;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  btp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_idx   (in_branch_pc[INDEX_BITS+1:2]),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_idx   (s1_pc_r[INDEX_BITS+1:2]),
    .wr_entry (wr_entry)
  );

  always_comb begin
    op      = s1_instr_r[6:0];
    is_xfer = (op == OP_BRANCH) || (op == OP_JAL) || (op == OP_JALR);
    hit     = rd_entry.valid && (rd_entry.tag == s1_pc_r);
    taken   = s1_next_r != (s1_pc_r + 32'd4);

    case (op)
      OP_BRANCH: target_new = s1_pc_r + imm_b(s1_instr_r);
      OP_JAL:    target_new = s1_pc_r + imm_j(s1_instr_r);
      default:   target_new = s1_next_r;
    endcase

    // a fresh allocation starts strong not-taken
    target_use = hit ? rd_entry.target : target_new;
    ctr_cur    = hit ? rd_entry.ctr : CTR_STRONG_NT;

    case (mode_r)
      MODE_TAKEN:     pred = 1'b1;
      MODE_NOT_TAKEN: pred = 1'b0;
      default:        pred = ctr_cur[1];
    endcase

    case (mode_r)
      MODE_ONE_BIT: ctr_new = taken ? CTR_STRONG_T : CTR_STRONG_NT;
      MODE_TWO_BIT: begin
        if (taken && ctr_cur != CTR_STRONG_T) begin
          ctr_new = ctr_cur + 2'd1;
        end else if (!taken && ctr_cur != CTR_STRONG_NT) begin
          ctr_new = ctr_cur - 2'd1;
        end else begin
          ctr_new = ctr_cur;
        end
      end
      default: ctr_new = ctr_cur;
    endcase

    ok = pred == taken;

    wr_en           = s1_adv && is_xfer;
    wr_entry.valid  = 1'b1;
    wr_entry.tag    = s1_pc_r;
    wr_entry.target = target_use;
    wr_entry.ctr    = ctr_new;

    branch_total_nxt  = (branch_total_r == '1) ? branch_total_r : branch_total_r + 32'd1;
    correct_total_nxt = correct_total_r;
    if (ok && correct_total_r != '1) begin
      correct_total_nxt = correct_total_r + 32'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_TWO_BIT;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      correct_total_r <= '0;
      branch_total_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= mode_t'(cfg_predictor_mode);
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        branch_total_r  <= branch_total_nxt;
        correct_total_r <= correct_total_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pc_r    <= in_branch_pc;
      s1_instr_r <= in_instr_word;
      s1_next_r  <= in_next_pc;
    end
    if (s1_adv) begin
      // non-transfers report all zero, totals included
      out_is_branch_r <= is_xfer;
      out_hit_r       <= is_xfer && hit;
      out_pred_r      <= is_xfer && pred;
      out_taken_r     <= is_xfer && taken;
      out_correct_r   <= is_xfer && ok;
      out_target_r    <= is_xfer ? target_use : 32'd0;
    end
  end

  // totals shown with a transfer result are the values after this item
  logic [31:0] out_correct_total_r;
  logic [31:0] out_branch_total_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_correct_total_r <= is_xfer ? correct_total_nxt : 32'd0;
      out_branch_total_r  <= is_xfer ? branch_total_nxt : 32'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_is_branch       = out_is_branch_r;
  assign out_hit             = out_hit_r;
  assign out_predicted_taken = out_pred_r;
  assign out_actual_taken    = out_taken_r;
  assign out_correct         = out_correct_r;
  assign out_target_addr     = out_target_r;
  assign out_correct_total   = out_correct_total_r;
  assign out_branch_total    = out_branch_total_r;

`ifndef NO_ASSERTIONS
  a_correct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    correct_total_r <= branch_total_r)
    else $error("correct count exceeds transfer count");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked lookup stage");

  a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_branch_r) |->
      (out_correct_r == (out_pred_r == out_taken_r)))
    else $error("correct flag disagrees with prediction and outcome");

  a_total_counts_item: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (branch_total_r != 32'd0))
    else $error("transfer count did not advance");
`endif

endmodule
